/* hw/rtl/tccw_pkg.sv */
package tccw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;
  localparam int unsigned TAB_STEP    = 8;

  localparam logic [7:0] COLOR_RESET = 8'h07;
  localparam logic [7:0] BLANK_CHAR  = 8'h20;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0a;
  localparam logic [7:0] CH_CR       = 8'h0d;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef struct packed {
    op_e         operation;
    logic [7:0]  char_code;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [10:0] read_addr;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] read_data;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic decode;
    logic ptr_clr;
    logic scroll_rd;
    logic scroll_wr;
    logic fill_wr;
    logic fill_zero;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic is_clear;
    logic ptr_last;
    logic out_free;
  } status_t;

endpackage

/* hw/rtl/tccw_stream_if.sv */
interface tccw_in_if;
  logic                valid;
  logic                ready;
  tccw_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tccw_out_if;
  logic                valid;
  logic                ready;
  tccw_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/text_console_cell_writer.sv */
// Text console cell writer.
// in_i carries one item per command (put character, set cursor, clear, read
// cell); out_o returns exactly one item per input item, in order, with the
// linear cursor position and, for reads, the cell value. Both are
// valid/ready channels; an item moves when valid and ready are high.
// cfg_we_i/cfg_wdata_i write the attribute byte used for written and blank
// cells; write it only while the block is idle.
// Sequence: a put, set-cursor or read item is decoded, with at most one cell
// access, in the cycle after acceptance; its result is then loaded once the
// output register is free, and in_i is ready again in the cycle after the
// load. A put that runs off the last row scrolls: a read step and a write
// step per cell over all COLUMNS*ROWS cells through the one-read/one-write
// screen memory. A clear writes all COLUMNS*ROWS cells, one write each.
// After reset the screen memory is zeroed, one cell a cycle, over all
// COLUMNS*ROWS cells (2000 by default); in_i is not ready meanwhile.
// A result waiting on a stalled receiver does not block the next item: it is
// accepted and worked on, and its result waits until the register frees.
module text_console_cell_writer #(
  parameter int unsigned COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  tccw_in_if.sink    in_i,
  tccw_out_if.source out_o
);

  tccw_pkg::cmd_t    cmd;
  tccw_pkg::status_t status;
  logic              in_ready;

  assign in_i.ready = in_ready;

  tccw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tccw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_i.payload),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_o.payload)
  );

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> (cmd.decode && !in_ready))
    else $error("accepted item not decoded next cycle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("result register overwritten before it was taken");

  a_init_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fill_zero |-> (!in_ready && !cmd.decode && !cmd.out_load))
    else $error("item activity during reset clearing pass");

endmodule

/* hw/rtl/tccw_ctrl.sv */
module tccw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tccw_pkg::status_t status_i,
  output tccw_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_FILL,
    ST_RESP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.fill_wr   = 1'b1;
        cmd_o.fill_zero = 1'b1;
        if (status_i.ptr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        cmd_o.decode  = 1'b1;
        cmd_o.ptr_clr = 1'b1;
        if (status_i.need_scroll) begin
          state_d = ST_SCROLL_RD;
        end else if (status_i.is_clear) begin
          state_d = ST_FILL;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_SCROLL_RD: begin
        cmd_o.scroll_rd = 1'b1;
        state_d         = ST_SCROLL_WR;
      end
      ST_SCROLL_WR: begin
        cmd_o.scroll_wr = 1'b1;
        state_d         = status_i.ptr_last ? ST_RESP : ST_SCROLL_RD;
      end
      ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (status_i.ptr_last) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/tccw_datapath.sv */
module tccw_datapath #(
  parameter int unsigned COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  tccw_pkg::in_item_t  in_item_i,
  input  tccw_pkg::cmd_t      cmd_i,
  output tccw_pkg::status_t   status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tccw_pkg::out_item_t out_item_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned PW    = (AW > 11) ? AW : 11;
  localparam int unsigned XW    = CW + 1;

  localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_A   = AW'(CELLS - 1);
  localparam logic [AW-1:0] MOVE_END = AW'(CELLS - COLUMNS);
  localparam logic [XW-1:0] COLS_X   = XW'(COLUMNS);
  localparam logic [XW-1:0] TAB_X    = XW'(tccw_pkg::TAB_STEP);
  localparam logic [XW-1:0] TAB_MASK = ~XW'(tccw_pkg::TAB_STEP - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [7:0]    COLS_B   = 8'(COLUMNS);
  localparam logic [7:0]    ROWS_B   = 8'(ROWS);
  localparam logic [PW-1:0] COLS_P   = PW'(COLUMNS);
  localparam logic [PW-1:0] CELLS_P  = PW'(CELLS);

  logic [7:0]          color_q;
  tccw_pkg::in_item_t  item_q;
  logic [RW-1:0]       row_q, row_d, wrow;
  logic [CW-1:0]       col_q, col_d, wcol;
  logic [AW-1:0]       ptr_q;
  logic [15:0]         rd_q;
  logic [15:0]         mem [CELLS];
  logic                out_valid_q;
  tccw_pkg::out_item_t out_q;

  logic [XW-1:0] col_inc, col_tab;
  logic          nr, scroll, we_dec, re_dec, move;
  logic [15:0]   wdat, blank, wd;
  logic          we, re;
  logic [AW-1:0] wa, ra, wr_addr_dec;
  logic [PW-1:0] addr_ext, pos;
  logic          rd_ok;

  assign blank   = {color_q, tccw_pkg::BLANK_CHAR};
  assign col_inc = {1'b0, col_q} + XW'(1);
  assign col_tab = ({1'b0, col_q} + TAB_X) & TAB_MASK;

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    nr     = 1'b0;
    scroll = 1'b0;
    we_dec = 1'b0;
    re_dec = 1'b0;
    wrow   = row_q;
    wcol   = col_q;
    wdat   = {color_q, item_q.char_code};
    case (item_q.operation)
      tccw_pkg::OP_PUT: begin
        case (item_q.char_code)
          tccw_pkg::CH_NL: nr = 1'b1;
          tccw_pkg::CH_CR: col_d = '0;
          tccw_pkg::CH_TAB: begin
            if (col_tab >= COLS_X) nr = 1'b1;
            else col_d = col_tab[CW-1:0];
          end
          tccw_pkg::CH_BS: begin
            if (col_q != '0) begin
              col_d  = col_q - CW'(1);
              wcol   = col_q - CW'(1);
              we_dec = 1'b1;
              wdat   = blank;
            end else if (row_q != '0) begin
              row_d  = row_q - RW'(1);
              col_d  = LAST_COL;
              wrow   = row_q - RW'(1);
              wcol   = LAST_COL;
              we_dec = 1'b1;
              wdat   = blank;
            end
          end
          default: begin
            we_dec = 1'b1;
            if (col_inc >= COLS_X) nr = 1'b1;
            else col_d = col_inc[CW-1:0];
          end
        endcase
      end
      tccw_pkg::OP_SET: begin
        col_d = (item_q.pos_x >= COLS_B) ? LAST_COL : item_q.pos_x[CW-1:0];
        row_d = (item_q.pos_y >= ROWS_B) ? LAST_ROW : item_q.pos_y[RW-1:0];
      end
      tccw_pkg::OP_CLEAR: begin
        row_d = '0;
        col_d = '0;
      end
      tccw_pkg::OP_READ: re_dec = 1'b1;
      default: ;
    endcase
    if (nr) begin
      col_d = '0;
      if (row_q == LAST_ROW) scroll = 1'b1;
      else row_d = row_q + RW'(1);
    end
  end

  assign wr_addr_dec = AW'(AW'(wrow) * COLS_A) + AW'(wcol);
  assign addr_ext    = PW'(item_q.read_addr);
  assign rd_ok       = addr_ext < CELLS_P;
  assign move        = ptr_q < MOVE_END;

  // one port for the decode step and the scroll/fill sweeps
  assign we = (cmd_i.decode & we_dec) | cmd_i.scroll_wr | cmd_i.fill_wr;
  assign wa = cmd_i.decode ? wr_addr_dec : ptr_q;
  always_comb begin
    if (cmd_i.decode) begin
      wd = wdat;
    end else if (cmd_i.fill_zero) begin
      wd = '0;
    end else if (cmd_i.scroll_wr && move) begin
      wd = rd_q;
    end else begin
      wd = blank;
    end
  end
  assign re = (cmd_i.decode & re_dec) | (cmd_i.scroll_rd & move);
  assign ra = cmd_i.decode ? addr_ext[AW-1:0] : ptr_q + COLS_A;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) item_q <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= tccw_pkg::COLOR_RESET;
      row_q   <= '0;
      col_q   <= '0;
      ptr_q   <= '0;
    end else begin
      if (cfg_we_i) color_q <= cfg_wdata_i;
      if (cmd_i.decode) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.scroll_wr || cmd_i.fill_wr) begin
        ptr_q <= ptr_q + AW'(1);
      end
    end
  end

  assign pos = PW'(PW'(row_q) * COLS_P) + PW'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.cursor_pos <= pos[10:0];
      out_q.read_data  <= (item_q.operation == tccw_pkg::OP_READ && rd_ok) ? rd_q : 16'h0000;
    end
  end

  assign status_o.need_scroll = scroll;
  assign status_o.is_clear    = item_q.operation == tccw_pkg::OP_CLEAR;
  assign status_o.ptr_last    = ptr_q == LAST_A;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int COLS = int'(tccw_pkg::COLUMNS_DEF);
  localparam int ROWS = int'(tccw_pkg::ROWS_DEF);
  localparam int CELLS = COLS * ROWS;
  localparam int GAP_LONG_MAX = 40;
  localparam int RAND_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 215;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  tccw_in_if  in_if ();
  tccw_out_if out_if ();

  text_console_cell_writer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // shadow of the console state
  logic [15:0] screen_shadow [CELLS];
  int          cur_row;
  int          cur_col;
  logic [7:0]  attr_shadow;

  tccw_pkg::in_item_t  cmd_backlog [$];
  tccw_pkg::out_item_t due_results [$];

  int          errors;
  longint      cycle_cnt;
  longint      cycle_allowance;
  int          tx_gap;
  int          tx_quiet;
  int          rx_stall;
  int          rx_quiet;

  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, GAP_LONG_MAX);
  endfunction

  function automatic logic [15:0] blank_value();
    return {attr_shadow, tccw_pkg::BLANK_CHAR};
  endfunction

  // returns 1 when the screen scrolled
  function automatic bit next_line();
    int i;
    cur_col = 0;
    cur_row++;
    if (cur_row < ROWS) return 1'b0;
    for (i = 0; i < CELLS - COLS; i++) screen_shadow[i] = screen_shadow[i + COLS];
    for (i = CELLS - COLS; i < CELLS; i++) screen_shadow[i] = blank_value();
    cur_row = ROWS - 1;
    return 1'b1;
  endfunction

  function automatic bit shadow_put(logic [7:0] ch);
    bit scrolled;
    scrolled = 1'b0;
    if (ch == tccw_pkg::CH_NL) begin
      scrolled = next_line();
    end else if (ch == tccw_pkg::CH_CR) begin
      cur_col = 0;
    end else if (ch == tccw_pkg::CH_TAB) begin
      cur_col = (cur_col + int'(tccw_pkg::TAB_STEP)) & ~(int'(tccw_pkg::TAB_STEP) - 1);
      if (cur_col >= COLS) scrolled = next_line();
    end else if (ch == tccw_pkg::CH_BS) begin
      if (cur_col > 0) begin
        cur_col--;
        screen_shadow[cur_row * COLS + cur_col] = blank_value();
      end else if (cur_row > 0) begin
        cur_row--;
        cur_col = COLS - 1;
        screen_shadow[cur_row * COLS + cur_col] = blank_value();
      end
    end else begin
      screen_shadow[cur_row * COLS + cur_col] = {attr_shadow, ch};
      cur_col++;
      if (cur_col >= COLS) scrolled = next_line();
    end
    return scrolled;
  endfunction

  // updates the shadow, queues the expected item, returns a cycle budget for it
  function automatic int console_apply(tccw_pkg::in_item_t it);
    tccw_pkg::out_item_t res;
    int                  budget;
    int                  i;
    budget = 4 * (8 + 2 * GAP_LONG_MAX);
    res.read_data = '0;
    case (it.operation)
      tccw_pkg::OP_PUT: begin
        if (shadow_put(it.char_code)) budget += 4 * 2 * CELLS;
      end
      tccw_pkg::OP_SET: begin
        cur_col = (int'(it.pos_x) >= COLS) ? COLS - 1 : int'(it.pos_x);
        cur_row = (int'(it.pos_y) >= ROWS) ? ROWS - 1 : int'(it.pos_y);
      end
      tccw_pkg::OP_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_shadow[i] = blank_value();
        cur_row = 0;
        cur_col = 0;
        budget += 4 * CELLS;
      end
      default: begin
        if (int'(it.read_addr) < CELLS) res.read_data = screen_shadow[it.read_addr];
      end
    endcase
    res.cursor_pos = 11'(cur_row * COLS + cur_col);
    due_results.push_back(res);
    return budget;
  endfunction

  task automatic queue_cmd(tccw_pkg::op_e op, logic [7:0] ch, logic [7:0] px,
                           logic [7:0] py, logic [10:0] ra);
    tccw_pkg::in_item_t it;
    it.operation = op;
    it.char_code = ch;
    it.pos_x     = px;
    it.pos_y     = py;
    it.read_addr = ra;
    cmd_backlog.push_back(it);
  endtask

  function automatic tccw_pkg::in_item_t random_cmd();
    tccw_pkg::in_item_t it;
    int                 r;
    it.char_code = 8'($urandom_range(0, 255));
    it.pos_x     = 8'($urandom_range(0, 255));
    it.pos_y     = 8'($urandom_range(0, 255));
    it.read_addr = 11'($urandom_range(0, 2047));
    r = $urandom_range(0, 99);
    if (r < 55) it.operation = tccw_pkg::OP_PUT;
    else if (r < 70) it.operation = tccw_pkg::OP_SET;
    else if (r < 72) it.operation = tccw_pkg::OP_CLEAR;
    else it.operation = tccw_pkg::OP_READ;
    r = $urandom_range(0, 99);
    if (r < 6) it.char_code = tccw_pkg::CH_NL;
    else if (r < 12) it.char_code = tccw_pkg::CH_TAB;
    else if (r < 18) it.char_code = tccw_pkg::CH_BS;
    else if (r < 21) it.char_code = tccw_pkg::CH_CR;
    else if (r < 70) it.char_code = 8'($urandom_range(32, 126));
    if ($urandom_range(0, 9) < 7) it.pos_x = 8'($urandom_range(0, COLS - 1));
    r = $urandom_range(0, 99);
    if (r < 55) it.pos_y = 8'($urandom_range(0, ROWS - 1));
    else if (r < 70) it.pos_y = 8'($urandom_range(ROWS - 5, ROWS - 1));
    r = $urandom_range(0, 99);
    if (r < 60) it.read_addr = 11'($urandom_range(0, CELLS - 1));
    else if (r < 80) it.read_addr = 11'($urandom_range(CELLS - 2 * COLS, 2047));
    else it.read_addr = 11'($urandom_range(0, 2 * COLS - 1));
    return it;
  endfunction

  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_idle();
    @(negedge clk_i);
    while (cmd_backlog.size() != 0 || due_results.size() != 0 || in_if.valid)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_attr(logic [7:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    attr_shadow = value;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        cycle_allowance += console_apply(in_if.payload);
        tx_gap = pick_gap(tx_quiet);
      end else if (!in_if.valid && tx_gap > 0) begin
        tx_gap--;
      end
      if ((!in_if.valid || in_if.ready) && tx_gap == 0 && cmd_backlog.size() != 0) begin
        in_if.payload <= cmd_backlog.pop_front();
        in_if.valid   <= 1'b1;
      end else if (in_if.valid && in_if.ready) begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tccw_pkg::out_item_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: item with none expected: cursor_pos %0d read_data %h",
                   $time, out_if.payload.cursor_pos, out_if.payload.read_data);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (out_if.payload.cursor_pos !== want.cursor_pos) begin
            $display("%0t: cursor_pos expected %0d actual %0d",
                     $time, want.cursor_pos, out_if.payload.cursor_pos);
            errors++;
          end
          if (out_if.payload.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h",
                     $time, want.read_data, out_if.payload.read_data);
            errors++;
          end
        end
        rx_stall = pick_gap(rx_quiet);
      end else if (rx_stall > 0) begin
        rx_stall--;
      end else if ($urandom_range(0, 15) == 0) begin
        rx_stall = pick_gap(rx_quiet);
      end
      out_if.ready <= (rx_stall == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > cycle_allowance) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [7:0] attr_plan [RAND_PHASES];
    int         p;
    int         n;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 8'h00;
    errors          = 0;
    cycle_cnt       = 0;
    cycle_allowance = 4 * CELLS + 40000;
    tx_gap          = 0;
    tx_quiet        = 0;
    rx_stall        = 0;
    rx_quiet        = 0;
    cur_row         = 0;
    cur_col         = 0;
    attr_shadow     = tccw_pkg::COLOR_RESET;
    for (n = 0; n < CELLS; n++) screen_shadow[n] = '0;
    attr_plan[0] = 8'hFF;
    attr_plan[1] = 8'h00;
    attr_plan[2] = 8'($urandom_range(0, 255));
    attr_plan[3] = 8'h80;
    attr_plan[4] = 8'h0F;
    attr_plan[5] = 8'($urandom_range(0, 255));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset contents, out of range read, control bytes, clamping,
    // wrap with scroll, tab and newline scroll, backspace over a line, clear
    queue_cmd(tccw_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 11'(CELLS - 1));
    queue_cmd(tccw_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 11'h7FF);
    queue_cmd(tccw_pkg::OP_PUT, 8'h41, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_PUT, tccw_pkg::CH_BS, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_PUT, tccw_pkg::CH_BS, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_PUT, 8'h00, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_PUT, 8'hFF, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_PUT, tccw_pkg::CH_CR, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_PUT, tccw_pkg::CH_NL, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_SET, 8'h00, 8'hFF, 8'hFF, 11'd0);
    queue_cmd(tccw_pkg::OP_PUT, 8'h5A, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 11'(CELLS - COLS - 1));
    queue_cmd(tccw_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 11'(CELLS - 1));
    queue_cmd(tccw_pkg::OP_SET, 8'h00, 8'(COLS - 1), 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_SET, 8'h00, 8'h00, 8'h01, 11'd0);
    queue_cmd(tccw_pkg::OP_PUT, tccw_pkg::CH_BS, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 11'(COLS - 1));
    queue_cmd(tccw_pkg::OP_SET, 8'h00, 8'(COLS), 8'(ROWS), 11'd0);
    queue_cmd(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_PUT, tccw_pkg::CH_NL, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_CLEAR, 8'h00, 8'h00, 8'h00, 11'd0);
    queue_cmd(tccw_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 11'(CELLS - 1));

    for (p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      write_attr(attr_plan[p]);
      for (n = 0; n < ITEMS_PER_PHASE; n++) cmd_backlog.push_back(random_cmd());
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
